>>> hdl/irt_pkg.sv
// Shared widths, status codes and cell control type for the interval reservation table.
package irt_pkg;

   localparam int ID_WIDTH        = 16;
   localparam int TIME_PORT_WIDTH = 16;
   localparam int PRIO_WIDTH      = 2;
   localparam int STATUS_WIDTH    = 3;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_ADDED    = 3'd0,
      ST_CONFLICT = 3'd1,
      ST_FULL     = 3'd2,
      ST_LISTED   = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;   // shift the chain one cell down, new entry enters cell 0
      logic rotate;   // shift occupied entries one cell up, cell 0 wraps around
   } cell_ctrl_type;

endpackage

>>> hdl/interval_reservation_table.sv
// Top level of the interval reservation table: request control, cell chain, result register.
//
//  channel | direction | handshake                 | payload
//  req     | in        | req_valid / req_stall     | kind, event_id, start_time, end_time, prio
//  rsp     | out       | rsp_valid / rsp_stall     | status, out_id, out_start, out_end,
//          |           |                           | out_prio, last
//
// An add first captures the request, then runs the parallel overlap test across all cells
// and makes the decision. A list captures the request and then emits the stored entries; the
// chain rotates one cell per emitted entry, so cell 0 always holds the next entry to send.
// Reset is synchronous and clears only occupancy and control; no clearing pass is needed.
// A stalled result holds the chain and any pending add or list step until the result is taken.
module interval_reservation_table #(
   parameter int CAPACITY   = 16,
   parameter int TIME_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [irt_pkg::ID_WIDTH-1:0]         req_event_id,
   input  logic [irt_pkg::TIME_PORT_WIDTH-1:0]  req_start_time,
   input  logic [irt_pkg::TIME_PORT_WIDTH-1:0]  req_end_time,
   input  logic [irt_pkg::PRIO_WIDTH-1:0]       req_prio,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [irt_pkg::STATUS_WIDTH-1:0]     rsp_status,
   output logic [irt_pkg::ID_WIDTH-1:0]         rsp_out_id,
   output logic [irt_pkg::TIME_PORT_WIDTH-1:0]  rsp_out_start,
   output logic [irt_pkg::TIME_PORT_WIDTH-1:0]  rsp_out_end,
   output logic [irt_pkg::PRIO_WIDTH-1:0]       rsp_out_prio,
   output logic                                 rsp_last
);

   localparam int TimeW = (TIME_WIDTH < irt_pkg::TIME_PORT_WIDTH) ?
                          TIME_WIDTH : irt_pkg::TIME_PORT_WIDTH;
   localparam int PosW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IdxW  = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADD,
      S_LIST
   } state_type;

   state_type                         state_ff, state_in;
   logic [PosW-1:0]                   pos_ff, pos_in;

   logic [irt_pkg::ID_WIDTH-1:0]      q_id_ff, q_id_in;
   logic [TimeW-1:0]                  q_start_ff, q_start_in;
   logic [TimeW-1:0]                  q_end_ff, q_end_in;
   logic [irt_pkg::PRIO_WIDTH-1:0]    q_prio_ff, q_prio_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   irt_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [irt_pkg::ID_WIDTH-1:0]      rsp_id_ff, rsp_id_in;
   logic [TimeW-1:0]                  rsp_start_ff, rsp_start_in;
   logic [TimeW-1:0]                  rsp_end_ff, rsp_end_in;
   logic [irt_pkg::PRIO_WIDTH-1:0]    rsp_prio_ff, rsp_prio_in;
   logic                              rsp_last_ff, rsp_last_in;

   irt_pkg::cell_ctrl_type            ctrl;

   logic [irt_pkg::ID_WIDTH-1:0]      c_id    [CAPACITY];
   logic [TimeW-1:0]                  c_start [CAPACITY];
   logic [TimeW-1:0]                  c_end   [CAPACITY];
   logic [irt_pkg::PRIO_WIDTH-1:0]    c_prio  [CAPACITY];
   logic [CAPACITY-1:0]               c_occ;
   logic [CAPACITY-1:0]               c_hit;
   logic [CAPACITY:0]                 occ_ext;

   logic                              any_hit;
   logic                              table_full;
   logic                              can_emit;
   logic                              list_last;

   // Build the chain: cell 0 holds the newest entry, higher cells older ones
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [irt_pkg::ID_WIDTH-1:0]   p_id, n_id;
      logic [TimeW-1:0]               p_start, p_end, n_start, n_end;
      logic [irt_pkg::PRIO_WIDTH-1:0] p_prio, n_prio;
      logic                           p_occ, n_occ;

      if (i == 0) begin : g_head
         assign p_id    = q_id_ff;
         assign p_start = q_start_ff;
         assign p_end   = q_end_ff;
         assign p_prio  = q_prio_ff;
         assign p_occ   = 1'b1;
      end else begin : g_body
         assign p_id    = c_id[i-1];
         assign p_start = c_start[i-1];
         assign p_end   = c_end[i-1];
         assign p_prio  = c_prio[i-1];
         assign p_occ   = c_occ[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign n_id    = c_id[0];
         assign n_start = c_start[0];
         assign n_end   = c_end[0];
         assign n_prio  = c_prio[0];
         assign n_occ   = 1'b0;
      end else begin : g_mid
         assign n_id    = c_id[i+1];
         assign n_start = c_start[i+1];
         assign n_end   = c_end[i+1];
         assign n_prio  = c_prio[i+1];
         assign n_occ   = c_occ[i+1];
      end

      irt_cell #(
         .TIME_W (TimeW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .prev_id     (p_id),
         .prev_start  (p_start),
         .prev_end    (p_end),
         .prev_prio   (p_prio),
         .prev_occ    (p_occ),
         .next_id     (n_id),
         .next_start  (n_start),
         .next_end    (n_end),
         .next_prio   (n_prio),
         .next_occ    (n_occ),
         .wrap_id     (c_id[0]),
         .wrap_start  (c_start[0]),
         .wrap_end    (c_end[0]),
         .wrap_prio   (c_prio[0]),
         .query_start (q_start_ff),
         .query_end   (q_end_ff),
         .cell_id     (c_id[i]),
         .cell_start  (c_start[i]),
         .cell_end    (c_end[i]),
         .cell_prio   (c_prio[i]),
         .cell_occ    (c_occ[i]),
         .cell_hit    (c_hit[i])
      );
   end

   assign any_hit    = |c_hit;
   assign table_full = c_occ[CAPACITY-1];
   assign occ_ext    = {1'b0, c_occ};
   assign can_emit   = !rsp_valid_ff || !rsp_stall;
   // The entry in cell 0 is the oldest when the cell past the listing position is empty
   assign list_last  = !occ_ext[IdxW'(pos_ff) + IdxW'(1)];

   // Sequence requests and load the result register
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      q_id_in       = q_id_ff;
      q_start_in    = q_start_ff;
      q_end_in      = q_end_ff;
      q_prio_in     = q_prio_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_last_in   = rsp_last_ff;
      ctrl          = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               q_id_in    = req_event_id;
               q_start_in = TimeW'(req_start_time);
               q_end_in   = TimeW'(req_end_time);
               q_prio_in  = req_prio;
               pos_in     = '0;
               state_in   = req_kind ? S_LIST : S_ADD;
            end
         end
         S_ADD: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = '0;
               rsp_start_in  = '0;
               rsp_end_in    = '0;
               rsp_prio_in   = '0;
               rsp_last_in   = 1'b1;
               if (any_hit) begin
                  rsp_status_in = irt_pkg::ST_CONFLICT;
               end else if (table_full) begin
                  rsp_status_in = irt_pkg::ST_FULL;
               end else begin
                  rsp_status_in = irt_pkg::ST_ADDED;
                  ctrl.insert   = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_LIST: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               if (!c_occ[0]) begin
                  rsp_status_in = irt_pkg::ST_EMPTY;
                  rsp_id_in     = '0;
                  rsp_start_in  = '0;
                  rsp_end_in    = '0;
                  rsp_prio_in   = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  rsp_status_in = irt_pkg::ST_LISTED;
                  rsp_id_in     = c_id[0];
                  rsp_start_in  = c_start[0];
                  rsp_end_in    = c_end[0];
                  rsp_prio_in   = c_prio[0];
                  rsp_last_in   = list_last;
                  ctrl.rotate   = 1'b1;
                  pos_in        = pos_ff + PosW'(1);
                  if (list_last) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, request and result registers
   always_ff @(posedge clock) begin
      q_id_ff       <= q_id_in;
      q_start_ff    <= q_start_in;
      q_end_ff      <= q_end_in;
      q_prio_ff     <= q_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_id    = rsp_id_ff;
   assign rsp_out_start = irt_pkg::TIME_PORT_WIDTH'(rsp_start_ff);
   assign rsp_out_end   = irt_pkg::TIME_PORT_WIDTH'(rsp_end_ff);
   assign rsp_out_prio  = rsp_prio_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

>>> hdl/irt_cell.sv
// One storage cell of the reservation chain: entry, occupancy and overlap test.
module irt_cell #(
   parameter int TIME_W = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  irt_pkg::cell_ctrl_type        ctrl,
   input  logic [irt_pkg::ID_WIDTH-1:0]  prev_id,
   input  logic [TIME_W-1:0]             prev_start,
   input  logic [TIME_W-1:0]             prev_end,
   input  logic [irt_pkg::PRIO_WIDTH-1:0] prev_prio,
   input  logic                          prev_occ,
   input  logic [irt_pkg::ID_WIDTH-1:0]  next_id,
   input  logic [TIME_W-1:0]             next_start,
   input  logic [TIME_W-1:0]             next_end,
   input  logic [irt_pkg::PRIO_WIDTH-1:0] next_prio,
   input  logic                          next_occ,
   input  logic [irt_pkg::ID_WIDTH-1:0]  wrap_id,
   input  logic [TIME_W-1:0]             wrap_start,
   input  logic [TIME_W-1:0]             wrap_end,
   input  logic [irt_pkg::PRIO_WIDTH-1:0] wrap_prio,
   input  logic [TIME_W-1:0]             query_start,
   input  logic [TIME_W-1:0]             query_end,
   output logic [irt_pkg::ID_WIDTH-1:0]  cell_id,
   output logic [TIME_W-1:0]             cell_start,
   output logic [TIME_W-1:0]             cell_end,
   output logic [irt_pkg::PRIO_WIDTH-1:0] cell_prio,
   output logic                          cell_occ,
   output logic                          cell_hit
);

   logic [irt_pkg::ID_WIDTH-1:0]   id_ff, id_in;
   logic [TIME_W-1:0]              start_ff, start_in;
   logic [TIME_W-1:0]              end_ff, end_in;
   logic [irt_pkg::PRIO_WIDTH-1:0] prio_ff, prio_in;
   logic                           occ_ff, occ_in;

   // Pick the next content: take from the newer side on insert, from the
   // older side (or the wrap source where the next cell is empty) on rotate
   always_comb begin
      id_in    = id_ff;
      start_in = start_ff;
      end_in   = end_ff;
      prio_in  = prio_ff;
      occ_in   = occ_ff;
      if (ctrl.insert) begin
         id_in    = prev_id;
         start_in = prev_start;
         end_in   = prev_end;
         prio_in  = prev_prio;
         occ_in   = prev_occ;
      end else if (ctrl.rotate) begin
         if (next_occ) begin
            id_in    = next_id;
            start_in = next_start;
            end_in   = next_end;
            prio_in  = next_prio;
         end else begin
            id_in    = wrap_id;
            start_in = wrap_start;
            end_in   = wrap_end;
            prio_in  = wrap_prio;
         end
      end
   end

   // Hold payload without reset, clear occupancy on reset
   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      prio_ff  <= prio_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // Strict half-open overlap against the stored interval
   assign cell_hit = occ_ff && (query_start < end_ff) && (query_end > start_ff);

   assign cell_id    = id_ff;
   assign cell_start = start_ff;
   assign cell_end   = end_ff;
   assign cell_prio  = prio_ff;
   assign cell_occ   = occ_ff;

endmodule
